@@ sv/aht_pkg.sv @@
`default_nettype none

package aht_pkg;

  localparam int TIME_W   = 32;
  localparam int HEAT_W   = 48;
  localparam int CNT_W    = 32;
  localparam int WEIGHT_W = 9;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // opcodes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_GET   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd1;

  // weight of one, in 1/256 units
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

  typedef logic [HEAT_W-1:0] heat_t;
  typedef logic [TIME_W-1:0] time_t;

endpackage

`default_nettype wire

@@ sv/access_heat_tracker.sv @@
`default_nettype none
// sequence: accept, time check, then the post step and result for add or get with no boundary crossed;
//   clear or an unused opcode skips the post step; a get with a pending count adds the blend states
// crossing a period boundary adds a bit-serial divide of elapsed time by the period, the decay
//   steps (DEC_A, DEC_B each) on the shared 48x9 multiplier, and the exit check
// one word in flight; next word taken the cycle after the result registers
// reset (synchronous, active low): tracker empty, heat and count zero, weight 128, period 60
module access_heat_tracker (
  input  wire                              clk,
  input  wire                              rst_n,
  // input words
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [aht_pkg::OP_W-1:0]         in_opcode,
  input  wire  [aht_pkg::TIME_W-1:0]       in_now_second,
  input  wire  [aht_pkg::CNT_W-1:0]        in_access_count,
  // result words
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [aht_pkg::HEAT_W-1:0]       out_heat,
  // configuration writes
  input  wire                              cfg_we,
  input  wire  [aht_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [aht_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import aht_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;  // time compare, decide catch-up
  localparam logic [3:0] S_DIV   = 4'd2;  // elapsed / period, one bit a cycle
  localparam logic [3:0] S_DEC_A = 4'd3;  // decay step: heat * (256 - w)
  localparam logic [3:0] S_DEC_B = 4'd4;  // decay step: + count * w
  localparam logic [3:0] S_POST  = 4'd5;  // apply add, or start get
  localparam logic [3:0] S_GET_A = 4'd6;
  localparam logic [3:0] S_GET_B = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;  // hand result to output register

  localparam int DIV_CNT_W = $clog2(TIME_W);
  localparam int PROD_W    = HEAT_W + WEIGHT_W;

  logic [3:0]           state_r, state_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  time_t                now_r, now_nxt;
  logic [CNT_W-1:0]     acnt_r, acnt_nxt;

  // tracked object state
  time_t                lpt_r, lpt_nxt;
  heat_t                heat_r, heat_nxt;
  heat_t                pcnt_r, pcnt_nxt;

  // config
  logic [WEIGHT_W-1:0]  weight_r, weight_nxt;
  time_t                period_r, period_nxt;

  // datapath scratch
  heat_t                acc_r, acc_nxt;
  heat_t                res_r, res_nxt;
  time_t                quo_r, quo_nxt;
  time_t                rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  time_t                step_cnt_r, step_cnt_nxt;
  logic                 first_r, first_nxt;

  logic                 out_valid_r, out_valid_nxt;
  heat_t                out_heat_r, out_heat_nxt;

  // derived values
  logic [WEIGHT_W-1:0]  w_eff;
  logic [WEIGHT_W-1:0]  w_inv;
  time_t                p_eff;
  time_t                elapsed;

  // shared multiplier
  heat_t                mul_a;
  logic [WEIGHT_W-1:0]  mul_b;
  logic [PROD_W-1:0]    mul_p;
  heat_t                mul_sh;
  heat_t                blend_sum;

  // divider slice
  logic [TIME_W:0]      rem_sh;
  logic                 div_ge;
  time_t                rem_step;
  time_t                quo_step;

  // count accumulate
  logic [HEAT_W:0]      pcnt_sum;

  assign w_eff   = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
  assign w_inv   = WEIGHT_ONE - w_eff;
  assign p_eff   = (period_r == '0) ? time_t'(1) : period_r;
  assign elapsed = now_r - lpt_r - time_t'(1);

  // a-phase scales the heat, b-phase scales the count
  always_comb begin
    if (state_r == S_DEC_A || state_r == S_GET_A) begin
      mul_a = heat_r;
      mul_b = w_inv;
    end else begin
      mul_a = pcnt_r;
      mul_b = w_eff;
    end
  end

  assign mul_p     = mul_a * mul_b;
  assign mul_sh    = mul_p[HEAT_W+7:8];
  assign blend_sum = acc_r + mul_sh;

  // restoring divide step
  assign rem_sh   = {rem_r, quo_r[TIME_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, p_eff});
  assign rem_step = div_ge ? TIME_W'(rem_sh - {1'b0, p_eff}) : rem_sh[TIME_W-1:0];
  assign quo_step = {quo_r[TIME_W-2:0], div_ge};

  assign pcnt_sum = {1'b0, pcnt_r} + {{(HEAT_W-CNT_W+1){1'b0}}, acnt_r};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_heat  = out_heat_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    now_nxt       = now_r;
    acnt_nxt      = acnt_r;
    lpt_nxt       = lpt_r;
    heat_nxt      = heat_r;
    pcnt_nxt      = pcnt_r;
    weight_nxt    = weight_r;
    period_nxt    = period_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    step_cnt_nxt  = step_cnt_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r;
    out_heat_nxt  = out_heat_r;

    // result drains independently of the sequencer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      if (cfg_index == REG_WEIGHT) begin
        weight_nxt = cfg_wdata[WEIGHT_W-1:0];
      end else if (cfg_index == REG_PERIOD) begin
        period_nxt = cfg_wdata[TIME_W-1:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          now_nxt   = in_now_second;
          acnt_nxt  = in_access_count;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        res_nxt = '0;
        if (op_r == OP_CLEAR) begin
          lpt_nxt   = '0;
          heat_nxt  = '0;
          pcnt_nxt  = '0;
          state_nxt = S_FIN;
        end else if (op_r != OP_ADD && op_r != OP_GET) begin
          // unused opcode: no state change, answers zero
          state_nxt = S_FIN;
        end else if (lpt_r > now_r) begin
          // time went backwards: start over
          lpt_nxt   = '0;
          heat_nxt  = '0;
          pcnt_nxt  = '0;
          state_nxt = S_POST;
        end else if (lpt_r == '0 || lpt_r == now_r || elapsed < p_eff) begin
          // empty, or no whole period elapsed
          state_nxt = S_POST;
        end else begin
          quo_nxt     = elapsed;
          rem_nxt     = '0;
          div_cnt_nxt = DIV_CNT_W'(TIME_W - 1);
          state_nxt   = S_DIV;
        end
      end

      S_DIV: begin
        quo_nxt     = quo_step;
        rem_nxt     = rem_step;
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          // advance start of period by whole periods: now - 1 - remainder
          lpt_nxt      = now_r - time_t'(1) - rem_step;
          step_cnt_nxt = quo_step;
          first_nxt    = 1'b1;
          state_nxt    = S_DEC_A;
        end
      end

      S_DEC_A: begin
        // later steps change nothing once heat is zero or weight is zero
        if (step_cnt_r == '0 || (!first_r && (heat_r == '0 || w_eff == '0))) begin
          state_nxt = S_POST;
        end else begin
          acc_nxt   = mul_sh;
          state_nxt = S_DEC_B;
        end
      end

      S_DEC_B: begin
        heat_nxt     = blend_sum;
        pcnt_nxt     = '0;
        step_cnt_nxt = step_cnt_r - 1'b1;
        first_nxt    = 1'b0;
        state_nxt    = S_DEC_A;
      end

      S_POST: begin
        if (op_r == OP_ADD) begin
          if (lpt_r == '0) begin
            lpt_nxt  = now_r;
            heat_nxt = '0;
            pcnt_nxt = {{(HEAT_W-CNT_W){1'b0}}, acnt_r};
          end else if (pcnt_sum[HEAT_W]) begin
            pcnt_nxt = '1;  // saturate
          end else begin
            pcnt_nxt = pcnt_sum[HEAT_W-1:0];
          end
          res_nxt   = '0;
          state_nxt = S_FIN;
        end else if (pcnt_r == '0) begin
          res_nxt   = heat_r;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_GET_A;
        end
      end

      S_GET_A: begin
        acc_nxt   = mul_sh;
        state_nxt = S_GET_B;
      end

      S_GET_B: begin
        res_nxt   = blend_sum;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_heat_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lpt_r       <= '0;
      heat_r      <= '0;
      pcnt_r      <= '0;
      weight_r    <= WEIGHT_W'(128);
      period_r    <= time_t'(60);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lpt_r       <= lpt_nxt;
      heat_r      <= heat_nxt;
      pcnt_r      <= pcnt_nxt;
      weight_r    <= weight_nxt;
      period_r    <= period_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    now_r      <= now_nxt;
    acnt_r     <= acnt_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    step_cnt_r <= step_cnt_nxt;
    first_r    <= first_nxt;
    out_heat_r <= out_heat_nxt;
  end

endmodule

`default_nettype wire

@@ tb/tb_access_heat_tracker.sv @@
`default_nettype none

module tb_access_heat_tracker;
  import aht_pkg::*;

  // codes the package leaves unnamed
  localparam logic [OP_W-1:0]      OP_NOP      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // register values after reset
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd128;
  localparam time_t               PERIOD_RESET = 32'd60;

  localparam logic [63:0] HEAT_MASK   = 64'h0000_FFFF_FFFF_FFFF;
  localparam time_t       TIME_MAX    = 32'hFFFF_FFFF;
  localparam int          HOLD_CYCLES = 300;
  // adds of the largest count that build up a large period count
  localparam int          BIG_ADDS    = 40;

  typedef enum {RX_OPEN, RX_RANDOM, RX_COMB} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                 in_valid;
  logic                 in_ready;
  logic [OP_W-1:0]      in_opcode;
  time_t                in_now_second;
  logic [CNT_W-1:0]     in_access_count;

  logic                 out_valid;
  logic                 out_ready;
  heat_t                out_heat;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  access_heat_tracker u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_now_second   (in_now_second),
    .in_access_count (in_access_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_heat        (out_heat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // heat tracker prediction: own copy of config and tracker state
  // ---------------------------------------------------------------------------
  logic [WEIGHT_W-1:0] cur_weight;
  time_t               cur_period;
  logic [63:0]         trk_time;   // start of current period, zero is empty
  logic [63:0]         trk_heat;
  logic [63:0]         trk_count;

  heat_t heat_expected[$];
  int    mismatches = 0;

  function automatic logic [63:0] eff_weight();
    logic [63:0] w;
    w = 64'(cur_weight);
    // weights above one count as one
    if (w > 64'(WEIGHT_ONE)) w = 64'(WEIGHT_ONE);
    return w;
  endfunction

  // one moving-average step, each product floored on its own
  function automatic logic [63:0] blend_heat(input logic [63:0] h, input logic [63:0] c);
    logic [63:0] w;
    logic [63:0] one;
    w   = eff_weight();
    one = 64'(WEIGHT_ONE);
    return ((h * (one - w)) / one + (c * w) / one) & HEAT_MASK;
  endfunction

  function automatic void clear_tracker();
    trk_time  = 0;
    trk_heat  = 0;
    trk_count = 0;
  endfunction

  // decay steps for every whole period that ended before t
  function automatic void decay_to(input logic [63:0] t);
    logic [63:0] p;
    logic [63:0] n;
    logic [63:0] i;
    // time going back wipes the tracker
    if (trk_time > t) begin
      clear_tracker();
      return;
    end
    if (trk_time == 0 || t == trk_time) return;
    p = (cur_period == 0) ? 64'd1 : {32'd0, cur_period};
    n = (t - trk_time - 64'd1) / p;
    for (i = 0; i < n; i++) begin
      // once heat is zero or weight is zero the remaining steps change nothing
      if (i > 0 && (trk_heat == 0 || eff_weight() == 0)) break;
      trk_heat  = blend_heat(trk_heat, trk_count);
      trk_count = 0;
    end
    trk_time = (trk_time + n * p) & 64'hFFFF_FFFF;
  endfunction

  function automatic heat_t apply_word(input logic [OP_W-1:0] op, input time_t t_s,
                                       input logic [CNT_W-1:0] cnt);
    logic [63:0] t;
    logic [63:0] c;
    logic [63:0] heat;
    t    = 64'(t_s);
    c    = 64'(cnt);
    heat = 0;
    case (op)
      OP_CLEAR: begin
        clear_tracker();
      end
      OP_ADD: begin
        decay_to(t);
        if (trk_time == 0) begin
          // empty: start tracking here, an add at time zero keeps it empty
          trk_time  = t;
          trk_heat  = 0;
          trk_count = c;
        end else begin
          trk_count = trk_count + c;
          if (trk_count > HEAT_MASK) trk_count = HEAT_MASK;
        end
      end
      OP_GET: begin
        decay_to(t);
        heat = (trk_count == 0) ? trk_heat : blend_heat(trk_heat, trk_count);
      end
      default: begin
      end
    endcase
    return heat[HEAT_W-1:0];
  endfunction

  task automatic flag_mismatch(input string what, input heat_t want, input heat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected heat %0d, got %0d", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // monitor: config writes, accepted words, result check against oldest entry
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    heat_t want;
    if (!rst_n) begin
      cur_weight = WEIGHT_RESET;
      cur_period = PERIOD_RESET;
      clear_tracker();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WEIGHT: cur_weight = cfg_wdata[WEIGHT_W-1:0];
          REG_PERIOD: cur_period = cfg_wdata[TIME_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready)
        heat_expected.push_back(apply_word(in_opcode, in_now_second, in_access_count));
      if (out_valid && out_ready) begin
        if (heat_expected.size() == 0) begin
          flag_mismatch("result with nothing pending", '0, out_heat);
        end else begin
          want = heat_expected.pop_front();
          if (out_heat !== want) flag_mismatch("heat mismatch", want, out_heat);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: stall pattern of its own, plus long holds on request
  // ---------------------------------------------------------------------------
  int hold_asked = 0;
  int hold_done  = 0;

  initial begin : result_sink
    rx_mode_t mode;
    int       stretch;
    int       hold_left;
    int       phase;
    mode      = RX_OPEN;
    stretch   = 0;
    hold_left = 0;
    phase     = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_asked != hold_done) begin
        // long hold, counted here so the sender keeps pushing meanwhile
        hold_done++;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = rx_mode_t'($urandom_range(0, 2));
          stretch = $urandom_range(16, 96);
        end
        stretch--;
        phase++;
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
          default:   out_ready <= (phase % 5) < 3;  // high while phase mod 5 is below 3, low otherwise
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // word side: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  int burst_left     = 0;
  bit sender_idle_en = 1'b1;

  // called just after the clock rises; returns as the tracker takes the word
  task automatic send_word(input logic [OP_W-1:0] op, input time_t t,
                           input logic [CNT_W-1:0] cnt);
    int gap;
    if (sender_idle_en && burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_now_second   <= t;
    in_access_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // let every pending result come back, then a few idle cycles
  task automatic finish_phase();
    in_valid <= 1'b0;
    // wait for an edge so the word taken last is already queued
    @(posedge clk);
    while (heat_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty tracker, add at time zero, unused opcode, clear with all ones
  task automatic test_empty_start();
    send_word(OP_GET, 32'd0, 32'd0);
    send_word(OP_ADD, 32'd0, 32'd100);       // stays empty but holds the count
    send_word(OP_GET, 32'd5, 32'd0);         // blend of pending count
    send_word(OP_ADD, 32'd7, 32'd3);         // starts tracking
    send_word(OP_NOP, TIME_MAX, 32'hFFFF_FFFF);
    send_word(OP_CLEAR, TIME_MAX, 32'hFFFF_FFFF);
    send_word(OP_GET, 32'd9, 32'd0);
  endtask

  // period boundaries at reset config, then a huge jump to the last second
  task automatic test_period_catch_up();
    send_word(OP_ADD, 32'd1000, 32'hFFFF_FFFF);
    send_word(OP_ADD, 32'd1030, 32'd1);
    send_word(OP_GET, 32'd1060, 32'd0);      // exactly one period, no step yet
    send_word(OP_GET, 32'd1061, 32'd0);      // first step
    send_word(OP_ADD, 32'd1061, 32'd0);
    send_word(OP_GET, 32'd1200, 32'd0);
    send_word(OP_GET, 32'd1500, 32'd0);      // nothing pending, plain heat
    send_word(OP_ADD, 32'hFFFF_FFF0, 32'd0); // many steps, heat dies out
    send_word(OP_GET, TIME_MAX, 32'd0);
  endtask

  // time going back clears everything before the word proceeds
  task automatic test_time_reversal();
    send_word(OP_ADD, 32'd5000, 32'd77);
    send_word(OP_GET, 32'd4999, 32'd0);
    send_word(OP_ADD, 32'd4000, 32'd8);
    send_word(OP_GET, 32'd3999, 32'd0);
    send_word(OP_GET, 32'd4000, 32'd0);
  endtask

  // receiver holds off while words keep coming, the block has to stall its input
  task automatic test_output_backpressure();
    int    k;
    time_t t;
    sender_idle_en = 1'b0;
    t = 32'd20000;
    hold_asked++;
    for (k = 0; k < 12; k++) begin
      t = t + $urandom_range(0, 90);
      send_word((k % 2 == 0) ? OP_ADD : OP_GET, t, $urandom);
    end
    sender_idle_en = 1'b1;
  endtask

  // segments of random traffic, each under its own weight and period
  task automatic test_random_traffic();
    int                  seg;
    int                  k;
    int                  pick;
    logic [WEIGHT_W-1:0] w;
    time_t               p;
    time_t               span;
    time_t               t;
    logic [OP_W-1:0]     op;
    logic [CNT_W-1:0]    cnt;
    logic [31:0]         junk;
    for (seg = 0; seg < 8; seg++) begin
      finish_phase();
      case (seg)
        0:       begin w = 9'd0;   p = 32'd1;        end
        1:       begin w = 9'd1;   p = 32'd0;        end  // zero period acts as one
        2:       begin w = 9'd256; p = 32'd7;        end
        3:       begin w = 9'd511; p = TIME_MAX;     end  // above one, longest period
        4:       begin w = 9'd300; p = 32'd2;        end
        7:       begin w = WEIGHT_RESET; p = PERIOD_RESET; end
        default: begin
          w = WEIGHT_W'($urandom_range(0, 511));
          p = $urandom_range(1, 30);
        end
      endcase
      // upper data bits above the weight field must not matter
      junk = $urandom;
      write_reg(REG_WEIGHT, {junk[31:WEIGHT_W], w});
      write_reg(REG_PERIOD, p);
      // writes to unused indexes go nowhere
      write_reg(REG_SPARE_A, $urandom);
      write_reg(REG_SPARE_B, $urandom);
      span = (p == 0) ? 32'd1 : ((p > 100) ? 32'd100 : p);
      sender_idle_en = ($urandom_range(0, 3) != 0);
      t = $urandom_range(1, 1000);
      send_word(OP_CLEAR, t, $urandom);
      for (k = 0; k < 90; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2)      t = $urandom;                          // jump anywhere
        else if (pick < 5) t = t - $urandom_range(1, 50);         // step back
        else               t = t + $urandom_range(0, 3 * span);   // usual case
        case ($urandom_range(0, 3))
          0:       cnt = $urandom_range(0, 20);
          1:       cnt = $urandom;
          2:       cnt = 32'hFFFF_FFFF;
          default: cnt = $urandom_range(0, 5000);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = OP_ADD;
        else if (pick < 88) op = OP_GET;
        else if (pick < 95) op = OP_CLEAR;
        else                op = OP_NOP;
        send_word(op, t, cnt);
      end
    end
    sender_idle_en = 1'b1;
  endtask

  // large period count from repeated largest adds, read back at full weight
  task automatic test_count_accumulate();
    int k;
    finish_phase();
    write_reg(REG_WEIGHT, CFG_DATA_W'(WEIGHT_ONE));
    write_reg(REG_PERIOD, TIME_MAX);
    sender_idle_en = 1'b0;
    send_word(OP_CLEAR, 32'd10, 32'd0);
    for (k = 0; k < BIG_ADDS; k++) send_word(OP_ADD, 32'd10, 32'hFFFF_FFFF);
    send_word(OP_GET, 32'd10, 32'd0);
    send_word(OP_GET, 32'd11, 32'd0);
    sender_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_opcode       <= OP_CLEAR;
    in_now_second   <= '0;
    in_access_count <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_WEIGHT;
    cfg_wdata       <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_start();
    test_period_catch_up();
    test_time_reversal();
    test_output_backpressure();
    test_random_traffic();
    test_count_accumulate();

    // drain, then leave room for any stray result
    finish_phase();
    repeat (64) @(posedge clk);
    if (mismatches == 0 && heat_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
